// ----- design/page_block_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Page block allocator assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_BLOCK_ALLOCATOR_DEFINES_SVH
`define PAGE_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("allocator assertion failed (same cycle)");

// Next-cycle implication, checked on every rising edge out of reset.
`define PBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("allocator assertion failed (next cycle)");

`endif

// ----- design/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// Page block allocator package
// Beat types, command and status bundles, codes and helpers.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int ADDR_W = 11;
	localparam int REQ_W  = 9;
	localparam int PS_W   = 10;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_TOOBIG  = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;

	localparam logic [1:0] MODE_EMPTY   = 2'd0;
	localparam logic [1:0] MODE_DIVIDED = 2'd1;
	localparam logic [1:0] MODE_WHOLE   = 2'd2;

	localparam logic [2:0] OP_NONE       = 3'd0;
	localparam logic [2:0] OP_TAKE_WHOLE = 3'd1;
	localparam logic [2:0] OP_TAKE_BLOCK = 3'd2;
	localparam logic [2:0] OP_SPLIT      = 3'd3;
	localparam logic [2:0] OP_FREE_WHOLE = 3'd4;
	localparam logic [2:0] OP_FREE_BLOCK = 3'd5;

	localparam logic [1:0] DIV_PAGE  = 2'd0;
	localparam logic [1:0] DIV_BLOCK = 2'd1;
	localparam logic [1:0] DIV_COUNT = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct packed {
		logic              action;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted_address;
		logic [1:0]        status;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       pg_clr;
		logic       pg_next;
		logic       pg_load;
		logic       blk_clr;
		logic       blk_next;
		logic       blk_load;
		logic       div_start;
		logic [1:0] div_sel;
		logic [2:0] op;
		logic       fin;
		logic [1:0] fin_status;
		logic       fin_addr;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic too_big;
		logic is_large;
		logic pg_end;
		logic pg_empty;
		logic pg_whole;
		logic pg_divided;
		logic pg_fits;
		logic bit_set;
		logic div_busy;
		logic div_done;
		logic pg_oob;
		logic off_zero;
		logic bs_zero;
		logic rem_zero;
		logic blk_ok;
	} sts_t;

	// Requests are rounded up to whole words, with a floor of one word.
	function automatic logic [PS_W-1:0] round_up4(input logic [REQ_W-1:0] n);
		logic [PS_W-1:0] w;
		w = {1'b0, n};
		if (w < PS_W'(4)) begin
			return PS_W'(4);
		end
		return (w + PS_W'(3)) & ~PS_W'(3);
	endfunction

endpackage

// ----- design/pba_div.sv -----
// ----------------------------------------------------------------------------
// Page block allocator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pba_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pba_pkg::ADDR_W-1:0]    dividend,
	input  logic [pba_pkg::PS_W-1:0]      divisor,
	output logic                          busy,
	output logic                          done,
	output logic [pba_pkg::ADDR_W-1:0]    quot,
	output logic [pba_pkg::PS_W-1:0]      rem
);

	localparam int CW = $clog2(pba_pkg::ADDR_W + 1);

	logic [CW-1:0]                 cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [pba_pkg::ADDR_W-1:0]    dvd_q;
	logic [pba_pkg::PS_W-1:0]      dvs_q;
	logic [pba_pkg::PS_W:0]        rem_q;
	logic [pba_pkg::PS_W:0]        trial;
	logic                          ge;

	assign trial = {rem_q[pba_pkg::PS_W-1:0], dvd_q[pba_pkg::ADDR_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(pba_pkg::ADDR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
			dvd_q <= {dvd_q[pba_pkg::ADDR_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q[pba_pkg::PS_W-1:0];

endmodule

// ----- design/pba_datapath.sv -----
// ----------------------------------------------------------------------------
// Page block allocator datapath
// Page tables, block maps, scan counters, divider and result registers.
// ----------------------------------------------------------------------------
module pba_datapath #(
	parameter int NUM_PAGES  = 8,
	parameter int MAX_BLOCKS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pba_pkg::req_t               req,
	input  logic [pba_pkg::PS_W-1:0]    page_size,
	input  logic                        cfg_clear,
	input  pba_pkg::cmd_t               cmd,
	output pba_pkg::sts_t               sts,
	output pba_pkg::rsp_t               rsp
);

	localparam int PGC_W = $clog2(NUM_PAGES + 1);
	localparam int PG_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int BK_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int AW    = pba_pkg::ADDR_W;
	localparam int SW    = pba_pkg::PS_W;

	logic                  action_q;
	logic [SW-1:0]         sz_q;
	logic [AW-1:0]         addr_q;
	logic [PGC_W-1:0]      pg_q;
	logic [AW-1:0]         base_q;
	logic [BK_W-1:0]       blk_q;
	logic [AW-1:0]         off_q;
	logic [1:0]            mode_q [NUM_PAGES];
	logic [SW-1:0]         bs_q   [NUM_PAGES];
	logic [CNT_W-1:0]      fb_q   [NUM_PAGES];
	logic [MAX_BLOCKS-1:0] map_q  [NUM_PAGES];
	pba_pkg::rsp_t         pend_q;
	pba_pkg::rsp_t         rsp_q;

	logic [PG_W-1:0]       pg_idx;
	logic [SW-1:0]         cur_bs;
	logic [1:0]            cur_mode;
	logic [AW-1:0]         dvd;
	logic [SW-1:0]         dvs;
	logic                  d_busy;
	logic                  d_done;
	logic [AW-1:0]         d_quot;
	logic [SW-1:0]         d_rem;
	logic [CNT_W-1:0]      split_cnt;

	assign pg_idx   = pg_q[PG_W-1:0];
	assign cur_bs   = bs_q[pg_idx];
	assign cur_mode = mode_q[pg_idx];

	always_comb begin
		case (cmd.div_sel)
			pba_pkg::DIV_PAGE: begin
				dvd = addr_q;
				dvs = page_size;
			end
			pba_pkg::DIV_BLOCK: begin
				dvd = off_q;
				dvs = cur_bs;
			end
			default: begin
				dvd = {1'b0, page_size};
				dvs = sz_q;
			end
		endcase
	end

	pba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (d_busy),
		.done     (d_done),
		.quot     (d_quot),
		.rem      (d_rem)
	);

	assign split_cnt = (d_quot >= AW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
		: d_quot[CNT_W-1:0];

	always_comb begin
		sts.action     = action_q;
		sts.too_big    = sz_q > page_size;
		sts.is_large   = {sz_q, 1'b0} > {1'b0, page_size};
		sts.pg_end     = pg_q == PGC_W'(NUM_PAGES);
		sts.pg_empty   = cur_mode == pba_pkg::MODE_EMPTY;
		sts.pg_whole   = cur_mode == pba_pkg::MODE_WHOLE;
		sts.pg_divided = cur_mode == pba_pkg::MODE_DIVIDED;
		sts.pg_fits    = (cur_mode == pba_pkg::MODE_DIVIDED) && (cur_bs >= sz_q)
			&& (fb_q[pg_idx] != '0);
		sts.bit_set    = map_q[pg_idx][blk_q];
		sts.div_busy   = d_busy;
		sts.div_done   = d_done;
		sts.pg_oob     = d_quot >= AW'(NUM_PAGES);
		sts.off_zero   = off_q == '0;
		sts.bs_zero    = cur_bs == '0;
		sts.rem_zero   = d_rem == '0;
		sts.blk_ok     = (d_quot < AW'(MAX_BLOCKS))
			&& ((off_q + AW'(cur_bs)) <= AW'(page_size));
	end

	// Item capture, scan counters and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			sz_q     <= pba_pkg::round_up4(req.request_size);
			addr_q   <= req.address;
		end
		if (cmd.pg_clr) begin
			pg_q   <= '0;
			base_q <= '0;
			off_q  <= '0;
		end else if (cmd.pg_next) begin
			pg_q   <= pg_q + PGC_W'(1);
			base_q <= base_q + AW'(page_size);
		end else if (cmd.pg_load) begin
			pg_q  <= d_quot[PGC_W-1:0];
			off_q <= AW'(d_rem);
		end
		if (cmd.blk_clr) begin
			blk_q <= '0;
			off_q <= '0;
		end else if (cmd.blk_next) begin
			blk_q <= blk_q + BK_W'(1);
			off_q <= off_q + AW'(cur_bs);
		end else if (cmd.blk_load) begin
			blk_q <= d_quot[BK_W-1:0];
		end
		if (cmd.fin) begin
			pend_q.status          <= cmd.fin_status;
			pend_q.granted_address <= cmd.fin_addr ? (base_q + off_q) : '0;
		end
		if (cmd.out_load) begin
			rsp_q <= pend_q;
		end
	end

	// Page modes are the only table that needs clearing: block sizes and counts
	// are rewritten whenever a page leaves the empty mode, the block map on a split.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PAGES; p++) begin
				mode_q[p] <= pba_pkg::MODE_EMPTY;
			end
		end else if (cfg_clear) begin
			for (int p = 0; p < NUM_PAGES; p++) begin
				mode_q[p] <= pba_pkg::MODE_EMPTY;
			end
		end else begin
			case (cmd.op)
				pba_pkg::OP_TAKE_WHOLE: mode_q[pg_idx] <= pba_pkg::MODE_WHOLE;
				pba_pkg::OP_SPLIT:      mode_q[pg_idx] <= pba_pkg::MODE_DIVIDED;
				pba_pkg::OP_FREE_WHOLE: mode_q[pg_idx] <= pba_pkg::MODE_EMPTY;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			pba_pkg::OP_TAKE_WHOLE: begin
				bs_q[pg_idx] <= page_size;
				fb_q[pg_idx] <= '0;
			end
			pba_pkg::OP_SPLIT: begin
				bs_q[pg_idx]  <= sz_q;
				fb_q[pg_idx]  <= split_cnt - CNT_W'(1);
				map_q[pg_idx] <= MAX_BLOCKS'(1);
			end
			pba_pkg::OP_TAKE_BLOCK: begin
				map_q[pg_idx][blk_q] <= 1'b1;
				fb_q[pg_idx]         <= fb_q[pg_idx] - CNT_W'(1);
			end
			pba_pkg::OP_FREE_BLOCK: begin
				map_q[pg_idx][blk_q] <= 1'b0;
				fb_q[pg_idx]         <= fb_q[pg_idx] + CNT_W'(1);
			end
			pba_pkg::OP_FREE_WHOLE: begin
				bs_q[pg_idx] <= '0;
			end
			default: ;
		endcase
	end

	assign rsp = rsp_q;

endmodule

// ----- design/pba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Page block allocator controller
// Sequences allocate and free operations over the datapath.
// ----------------------------------------------------------------------------
`include "page_block_allocator_defines.svh"

module pba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  pba_pkg::sts_t sts,
	output pba_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ALLOC  = 4'd1;
	localparam logic [3:0] S_WHOLE  = 4'd2;
	localparam logic [3:0] S_DSCAN  = 4'd3;
	localparam logic [3:0] S_BITS   = 4'd4;
	localparam logic [3:0] S_SPLIT  = 4'd5;
	localparam logic [3:0] S_SDIV   = 4'd6;
	localparam logic [3:0] S_FSTART = 4'd7;
	localparam logic [3:0] S_FDIV   = 4'd8;
	localparam logic [3:0] S_FMODE  = 4'd9;
	localparam logic [3:0] S_FDIV2  = 4'd10;
	localparam logic [3:0] S_FBIT   = 4'd11;
	localparam logic [3:0] S_RESULT = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       rsp_valid_q;

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ALLOC;
				end
			end
			S_ALLOC: begin
				cmd.pg_clr = 1'b1;
				if (sts.action != pba_pkg::ACT_ALLOC) begin
					state_d = S_FSTART;
				end else if (sts.too_big) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = pba_pkg::ST_TOOBIG;
					state_d        = S_RESULT;
				end else if (sts.is_large) begin
					state_d = S_WHOLE;
				end else begin
					state_d = S_DSCAN;
				end
			end
			S_WHOLE: begin
				if (sts.pg_end) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = pba_pkg::ST_NOMEM;
					state_d        = S_RESULT;
				end else if (sts.pg_empty) begin
					cmd.op         = pba_pkg::OP_TAKE_WHOLE;
					cmd.fin        = 1'b1;
					cmd.fin_status = pba_pkg::ST_OK;
					cmd.fin_addr   = 1'b1;
					state_d        = S_RESULT;
				end else begin
					cmd.pg_next = 1'b1;
				end
			end
			S_DSCAN: begin
				if (sts.pg_end) begin
					cmd.pg_clr = 1'b1;
					state_d    = S_SPLIT;
				end else if (sts.pg_fits) begin
					cmd.blk_clr = 1'b1;
					state_d     = S_BITS;
				end else begin
					cmd.pg_next = 1'b1;
				end
			end
			S_BITS: begin
				if (!sts.bit_set) begin
					cmd.op         = pba_pkg::OP_TAKE_BLOCK;
					cmd.fin        = 1'b1;
					cmd.fin_status = pba_pkg::ST_OK;
					cmd.fin_addr   = 1'b1;
					state_d        = S_RESULT;
				end else begin
					cmd.blk_next = 1'b1;
				end
			end
			S_SPLIT: begin
				if (sts.pg_end) begin
					cmd.fin        = 1'b1;
					cmd.fin_status = pba_pkg::ST_NOMEM;
					state_d        = S_RESULT;
				end else if (sts.pg_empty) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = pba_pkg::DIV_COUNT;
					state_d       = S_SDIV;
				end else begin
					cmd.pg_next = 1'b1;
				end
			end
			S_SDIV: begin
				cmd.div_sel = pba_pkg::DIV_COUNT;
				if (sts.div_done) begin
					cmd.op         = pba_pkg::OP_SPLIT;
					cmd.fin        = 1'b1;
					cmd.fin_status = pba_pkg::ST_OK;
					cmd.fin_addr   = 1'b1;
					state_d        = S_RESULT;
				end
			end
			S_FSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = pba_pkg::DIV_PAGE;
				state_d       = S_FDIV;
			end
			S_FDIV: begin
				if (sts.div_done) begin
					if (sts.pg_oob) begin
						cmd.fin        = 1'b1;
						cmd.fin_status = pba_pkg::ST_BADFREE;
						state_d        = S_RESULT;
					end else begin
						cmd.pg_load = 1'b1;
						state_d     = S_FMODE;
					end
				end
			end
			S_FMODE: begin
				cmd.fin        = 1'b1;
				cmd.fin_status = pba_pkg::ST_BADFREE;
				state_d        = S_RESULT;
				if (sts.pg_whole && sts.off_zero) begin
					cmd.op         = pba_pkg::OP_FREE_WHOLE;
					cmd.fin_status = pba_pkg::ST_OK;
				end else if (sts.pg_divided && !sts.bs_zero) begin
					cmd.fin       = 1'b0;
					cmd.div_start = 1'b1;
					cmd.div_sel   = pba_pkg::DIV_BLOCK;
					state_d       = S_FDIV2;
				end
			end
			S_FDIV2: begin
				cmd.div_sel = pba_pkg::DIV_BLOCK;
				if (sts.div_done) begin
					if (sts.rem_zero && sts.blk_ok) begin
						cmd.blk_load = 1'b1;
						state_d      = S_FBIT;
					end else begin
						cmd.fin        = 1'b1;
						cmd.fin_status = pba_pkg::ST_BADFREE;
						state_d        = S_RESULT;
					end
				end
			end
			S_FBIT: begin
				cmd.fin        = 1'b1;
				cmd.fin_status = pba_pkg::ST_BADFREE;
				state_d        = S_RESULT;
				if (sts.bit_set) begin
					cmd.op         = pba_pkg::OP_FREE_BLOCK;
					cmd.fin_status = pba_pkg::ST_OK;
				end
			end
			S_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`PBA_ASSERT_IMP(a_div_idle, clk, arst_n, cmd.div_start, !sts.div_busy)
	`PBA_ASSERT_IMP(a_op_fin, clk, arst_n, cmd.op != pba_pkg::OP_NONE, cmd.fin)
	`PBA_ASSERT_NXT(a_result_out, clk, arst_n, state_q == S_RESULT && (!rsp_valid_q || rsp_ready), rsp_valid_q && state_q == S_IDLE)

endmodule

// ----- design/page_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Page block allocator
// Slab allocator over a pool of equal pages, with an APB page size register.
// ----------------------------------------------------------------------------
// Each request beat is handled one at a time and answered with exactly one
// response beat. An allocate visits up to NUM_PAGES pages in each page
// scan and steps over up to MAX_BLOCKS used blocks in the chosen page;
// splitting a new page adds a block count division. A free makes one or
// two passes through the shared 11-step restoring divider that splits the
// address into page, offset and block. The response sits in an output
// register, so the next request beat is accepted while an earlier response
// still waits to be taken. Writing the page size register empties the
// whole pool; write it only while the block is idle.
module page_block_allocator #(
	parameter int NUM_PAGES      = 8,
	parameter int PAGE_MAX_BYTES = 256,
	parameter int MAX_BLOCKS     = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	// Configuration port. The page size register is at byte address 0.
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	// Request channel.
	input  logic          req_valid,
	output logic          req_ready,
	input  pba_pkg::req_t req,
	// Response channel.
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pba_pkg::rsp_t rsp
);

	localparam int SW = pba_pkg::PS_W;
	localparam logic [1:0] REG_PAGE_SIZE = 2'd0;
	localparam logic [SW-1:0] PS_RESET =
		SW'((PAGE_MAX_BYTES < 256) ? PAGE_MAX_BYTES : 256);

	logic [SW-1:0]  page_size_q;
	logic [SW-1:0]  ps_round;
	logic [SW-1:0]  ps_new;
	logic           cfg_wr;
	logic           cfg_clear;
	pba_pkg::cmd_t  cmd;
	pba_pkg::sts_t  sts;

	// The register accepts a write on the access phase; pready never stalls.
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign cfg_clear = cfg_wr && (paddr == REG_PAGE_SIZE);

	// The written size is rounded up to whole words and held to the page
	// ceiling.
	assign ps_round = pba_pkg::round_up4(pwdata[pba_pkg::REQ_W-1:0]);
	assign ps_new   = (32'(ps_round) > 32'(PAGE_MAX_BYTES)) ? SW'(PAGE_MAX_BYTES)
		: ps_round;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PS_RESET;
		end else if (cfg_clear) begin
			page_size_q <= ps_new;
		end
	end

	assign prdata = (paddr == REG_PAGE_SIZE) ? 32'(page_size_q) : '0;

	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pba_datapath #(
		.NUM_PAGES  (NUM_PAGES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.page_size (page_size_q),
		.cfg_clear (cfg_clear),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

// ----- bench/page_block_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page block allocator testbench
// Drives allocate and free beats through the allocator, predicts every
// response with a behavioral model of the page pool, and checks each response
// beat in order. The page size register is rewritten between phases.
// ----------------------------------------------------------------------------
module page_block_allocator_tb;

	localparam int NPAGES     = 8;
	localparam int PAGE_LIMIT = 256;
	localparam int BLK_LIMIT  = 64;
	localparam int WATCHDOG   = 20000;
	localparam int DRAIN      = 200;

	// Idle patterns: percentage of cycles each side holds off.
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	logic          clk;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [1:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;
	logic          req_valid;
	logic          req_ready;
	pba_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	pba_pkg::rsp_t rsp;

	page_block_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Pool model state, mirroring the allocator's page tables.
	int unsigned          pool_page_size;
	logic [1:0]           pool_mode [NPAGES];
	int unsigned          pool_blk_size [NPAGES];
	logic [BLK_LIMIT-1:0] pool_used [NPAGES];
	int unsigned          pool_free_cnt [NPAGES];

	pba_pkg::rsp_t pending_rsp [$];
	int            mismatch_count;
	int            stall_cycles;
	idle_mode_e    idle_mode;

	// Page sizes written at the start of each random phase.
	int unsigned   phase_sizes [8] = '{4, 255, 0, 40, 256, 100, 13, 511};

	// Outstanding allocations, used to aim most frees at real blocks.
	logic [pba_pkg::ADDR_W-1:0] live_addr [$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned word_round(input int unsigned n);
		if (n < 4)
			return 4;
		return (n + 3) & ~32'd3;
	endfunction

	function automatic int unsigned blocks_in_page(input int unsigned bs);
		int unsigned c;
		c = pool_page_size / bs;
		return (c > BLK_LIMIT) ? BLK_LIMIT : c;
	endfunction

	function automatic void pool_clear();
		for (int p = 0; p < NPAGES; p++) begin
			pool_mode[p] = pba_pkg::MODE_EMPTY;
			pool_blk_size[p] = 0;
			pool_used[p] = '0;
			pool_free_cnt[p] = 0;
		end
	endfunction

	// Allocation: whole page for large sizes, else first fitting block,
	// else split the first empty page.
	function automatic pba_pkg::rsp_t pool_alloc(input int unsigned want);
		pba_pkg::rsp_t r;
		int unsigned sz;
		int unsigned cnt;
		r = '{granted_address: '0, status: pba_pkg::ST_OK};
		sz = word_round(want);
		if (sz > pool_page_size) begin
			r.status = pba_pkg::ST_TOOBIG;
			return r;
		end
		if (sz > pool_page_size / 2) begin
			for (int p = 0; p < NPAGES; p++) begin
				if (pool_mode[p] == pba_pkg::MODE_EMPTY) begin
					pool_mode[p] = pba_pkg::MODE_WHOLE;
					pool_blk_size[p] = pool_page_size;
					pool_free_cnt[p] = 0;
					r.granted_address = pba_pkg::ADDR_W'(p * pool_page_size);
					return r;
				end
			end
			r.status = pba_pkg::ST_NOMEM;
			return r;
		end
		for (int p = 0; p < NPAGES; p++) begin
			if (pool_mode[p] != pba_pkg::MODE_DIVIDED || pool_blk_size[p] < sz ||
					pool_free_cnt[p] == 0)
				continue;
			cnt = blocks_in_page(pool_blk_size[p]);
			for (int i = 0; i < cnt; i++) begin
				if (!pool_used[p][i]) begin
					pool_used[p][i] = 1'b1;
					pool_free_cnt[p]--;
					r.granted_address =
						pba_pkg::ADDR_W'(p * pool_page_size + i * pool_blk_size[p]);
					return r;
				end
			end
		end
		for (int p = 0; p < NPAGES; p++) begin
			if (pool_mode[p] == pba_pkg::MODE_EMPTY) begin
				pool_mode[p] = pba_pkg::MODE_DIVIDED;
				pool_blk_size[p] = sz;
				pool_used[p] = '0;
				pool_used[p][0] = 1'b1;
				pool_free_cnt[p] = blocks_in_page(sz) - 1;
				r.granted_address = pba_pkg::ADDR_W'(p * pool_page_size);
				return r;
			end
		end
		r.status = pba_pkg::ST_NOMEM;
		return r;
	endfunction

	function automatic pba_pkg::rsp_t pool_release(input int unsigned where);
		pba_pkg::rsp_t r;
		int unsigned p;
		int unsigned off;
		int unsigned bs;
		int unsigned i;
		r = '{granted_address: '0, status: pba_pkg::ST_BADFREE};
		p = where / pool_page_size;
		if (p >= NPAGES)
			return r;
		off = where - p * pool_page_size;
		if (pool_mode[p] == pba_pkg::MODE_WHOLE) begin
			if (off != 0)
				return r;
			pool_mode[p] = pba_pkg::MODE_EMPTY;
			pool_blk_size[p] = 0;
			r.status = pba_pkg::ST_OK;
			return r;
		end
		if (pool_mode[p] != pba_pkg::MODE_DIVIDED)
			return r;
		bs = pool_blk_size[p];
		if (bs == 0 || off % bs != 0)
			return r;
		i = off / bs;
		if (i >= blocks_in_page(bs) || !pool_used[p][i])
			return r;
		pool_used[p][i] = 1'b0;
		pool_free_cnt[p]++;
		r.status = pba_pkg::ST_OK;
		return r;
	endfunction

	function automatic pba_pkg::rsp_t pool_predict(input pba_pkg::req_t beat);
		if (beat.action == pba_pkg::ACT_ALLOC)
			return pool_alloc(beat.request_size);
		return pool_release(beat.address);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic bit roll_idle(input bit sender);
		case (idle_mode)
			IDLE_NONE: return 1'b0;
			IDLE_SEND: return sender ? ($urandom_range(99) < 80) : 1'b0;
			IDLE_RECV: return sender ? 1'b0 : ($urandom_range(99) < 80);
			default:   return $urandom_range(99) < 21;
		endcase
	endfunction

	// Response side: check each beat against the oldest prediction, and
	// stall at random according to the current idle mode.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response beat", 1, 0);
			end else begin
				pba_pkg::rsp_t want;
				want = pending_rsp.pop_front();
				if (rsp.granted_address !== want.granted_address)
					report_mismatch("granted_address", rsp.granted_address,
						want.granted_address);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
			end
		end
	end

	always @(negedge clk) begin
		rsp_ready <= arst_n && !roll_idle(1'b0);
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG) begin
			$display("watchdog expired with %0d responses pending", pending_rsp.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Sends one request beat; an optional fixed answer is checked against the
	// model, whose prediction is always the one queued for checking. Valid is
	// dropped only when the sender idles or the stream pauses.
	task automatic send_beat(input pba_pkg::req_t beat, input bit has_fixed,
			input pba_pkg::rsp_t fixed);
		pba_pkg::rsp_t want;
		while (roll_idle(1'b1)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = pool_predict(beat);
		if (has_fixed && want !== fixed)
			report_mismatch("directed table vs model", want, fixed);
		pending_rsp.push_back(want);
		if (beat.action == pba_pkg::ACT_ALLOC && want.status == pba_pkg::ST_OK)
			live_addr.push_back(want.granted_address);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// APB write: setup then access; pready is always high.
	task automatic write_page_size(input int unsigned value);
		int unsigned v;
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		v = word_round(value & 32'h1FF);
		pool_page_size = (v > PAGE_LIMIT) ? PAGE_LIMIT : v;
		pool_clear();
		live_addr.delete();
	endtask

	function automatic pba_pkg::req_t make_alloc(input int unsigned sz);
		return '{action: pba_pkg::ACT_ALLOC, request_size: pba_pkg::REQ_W'(sz),
			address: pba_pkg::ADDR_W'($urandom())};
	endfunction

	function automatic pba_pkg::req_t make_free(input int unsigned where);
		return '{action: pba_pkg::ACT_FREE, request_size: pba_pkg::REQ_W'($urandom()),
			address: pba_pkg::ADDR_W'(where)};
	endfunction

	// One random beat: mostly allocations of small sizes and frees of live
	// blocks, with some stray frees and oversize requests as noise.
	function automatic pba_pkg::req_t random_beat();
		int unsigned pick;
		int unsigned k;
		pick = $urandom_range(99);
		if (pick < 45) begin
			if ($urandom_range(9) == 0)
				return make_alloc($urandom_range(511));
			return make_alloc($urandom_range(pool_page_size));
		end
		if (pick < 85 && live_addr.size() != 0) begin
			k = $urandom_range(live_addr.size() - 1);
			pick = live_addr[k];
			live_addr.delete(k);
			return make_free(pick);
		end
		return make_free($urandom_range(2047));
	endfunction

	typedef struct {
		pba_pkg::req_t beat;
		bit            has_fixed;
		pba_pkg::rsp_t fixed;
	} stim_row_t;

	stim_row_t directed [$];

	function automatic void add_row(input pba_pkg::req_t beat, input bit has_fixed,
			input logic [pba_pkg::ADDR_W-1:0] a, input logic [1:0] s);
		stim_row_t row;
		row.beat = beat;
		row.has_fixed = has_fixed;
		row.fixed = '{granted_address: a, status: s};
		directed.push_back(row);
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		mismatch_count = 0;
		stall_cycles = 0;
		idle_mode = IDLE_NONE;
		pool_page_size = PAGE_LIMIT;
		pool_clear();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table at reset page size 256. Fixed answers are given
		// where they follow directly from an empty pool.
		add_row(make_free(0), 1, 0, pba_pkg::ST_BADFREE);      // free in an empty page
		add_row(make_free(2047), 1, 0, pba_pkg::ST_BADFREE);   // last byte, empty page
		add_row(make_alloc(257), 1, 0, pba_pkg::ST_TOOBIG);    // oversize request
		add_row(make_alloc(511), 1, 0, pba_pkg::ST_TOOBIG);
		add_row(make_alloc(0), 1, 0, pba_pkg::ST_OK);          // rounds up to four
		add_row(make_alloc(1), 0, 0, pba_pkg::ST_OK);
		add_row(make_alloc(129), 1, 256, pba_pkg::ST_OK);      // whole page
		add_row(make_free(260), 1, 0, pba_pkg::ST_BADFREE);    // inside a whole page
		add_row(make_free(2), 1, 0, pba_pkg::ST_BADFREE);      // off a block boundary
		add_row(make_free(8), 1, 0, pba_pkg::ST_BADFREE);      // block not in use
		add_row(make_alloc(128), 0, 0, pba_pkg::ST_OK);        // half page is divided
		add_row(make_alloc(100), 0, 0, pba_pkg::ST_OK);
		add_row(make_free(256), 1, 0, pba_pkg::ST_OK);
		add_row(make_free(0), 1, 0, pba_pkg::ST_OK);
		add_row(make_free(4), 1, 0, pba_pkg::ST_OK);           // page left divided, empty
		add_row(make_alloc(3), 0, 0, pba_pkg::ST_OK);
		add_row(make_alloc(256), 0, 0, pba_pkg::ST_OK);
		for (int i = 0; i < 8; i++)
			add_row(make_alloc(256), 0, 0, pba_pkg::ST_OK);    // runs out of pages
		foreach (directed[i])
			send_beat(directed[i].beat, directed[i].has_fixed, directed[i].fixed);
		wait_drained();

		// Random phases over several page sizes, each idle mode in turn.
		// Page size 4 caps at one block; 256 hits the block count cap.
		foreach (phase_sizes[ph]) begin
			write_page_size(phase_sizes[ph]);
			idle_mode = idle_mode_e'(ph % 4);
			for (int n = 0; n < 55; n++) begin
				if (ph == 2 && n == 20)
					wait_drained();
				send_beat(random_beat(), 0, '0);
			end
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
